// File: rtl/fmtp_pkg.sv
package fmtp_pkg;

    localparam logic [2:0] FUNC_TICK1  = 3'd0;
    localparam logic [2:0] FUNC_TICK2  = 3'd1;
    localparam logic [2:0] FUNC_WRITE  = 3'd2;
    localparam logic [2:0] FUNC_STATUS = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    localparam logic [10:0] NATIVE_BASE   = 11'h400;
    localparam logic [10:0] READ_MASK     = 11'h5ff;
    localparam logic [10:0] READ_RELOAD1  = 11'h402;
    localparam logic [10:0] READ_RELOAD2  = 11'h403;
    localparam logic [10:0] READ_CONTROL  = 11'h404;

    localparam logic [8:0] REG_RELOAD1 = 9'h002;
    localparam logic [8:0] REG_RELOAD2 = 9'h003;
    localparam logic [8:0] REG_CONTROL = 9'h004;

    localparam logic [7:0] NO_ANSWER = 8'hff;

    localparam logic CFG_HIGH_MAP  = 1'b0;
    localparam logic CFG_OPL3_MODE = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [10:0] reg_addr;
        logic [7:0]  wdata;
    } in_word_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       answered;
    } out_word_t;

    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
    } timer_cmd_t;

endpackage

// File: rtl/fmtp_in_if.sv
interface fmtp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [10:0] reg_addr;
    logic [7:0]  wdata;

    modport source (output valid, output func, output reg_addr, output wdata, input ready);
    modport sink (input valid, input func, input reg_addr, input wdata, output ready);
endinterface

// File: rtl/fmtp_out_if.sv
interface fmtp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] rdata;
    logic       answered;

    modport source (output valid, output rdata, output answered, input ready);
    modport sink (input valid, input rdata, input answered, output ready);
endinterface

// File: rtl/fmtp_timer.sv
module fmtp_timer
    import fmtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  timer_cmd_t cmd,
    input  logic [7:0] reload,
    input  logic       mask,
    input  logic       opl3,
    output logic       ovf
);

    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;
    logic       run_reg;
    logic       run_next;
    logic [7:0] base;
    logic       do_count;

    always_comb
    begin
        cnt_next = cnt_reg;
        run_next = run_reg;
        base     = cnt_reg;
        do_count = 1'b0;
        ovf      = 1'b0;
        if (cmd.start)
        begin
            run_next = 1'b1;
            base     = reload;
            cnt_next = reload;
            do_count = opl3;
        end
        else if (cmd.stop)
        begin
            run_next = 1'b0;
        end
        else if (cmd.tick && run_reg)
        begin
            do_count = 1'b1;
        end
        if (do_count)
        begin
            if (base == 8'hff)
            begin
                cnt_next = reload;
                ovf      = !mask;
            end
            else
            begin
                cnt_next = base + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
        end
    end

endmodule

// File: rtl/fmtp_core.sv
module fmtp_core
    import fmtp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_word_t  item,
    input  logic      high_map,
    input  logic      opl3_mode,
    output out_word_t result
);

    logic [1:0]  flags_reg;
    logic [1:0]  flags_next;
    logic [7:0]  control_reg;
    logic [7:0]  control_next;
    logic [7:0]  reload1_reg;
    logic [7:0]  reload1_next;
    logic [7:0]  reload2_reg;
    logic [7:0]  reload2_next;
    logic [10:0] waddr;
    logic [8:0]  wreg;
    logic [10:0] raddr;
    logic        ctl_write;
    logic        clear_all;
    timer_cmd_t  cmd1;
    timer_cmd_t  cmd2;
    logic        ovf1;
    logic        ovf2;

    assign waddr = high_map ? (item.reg_addr - NATIVE_BASE) : item.reg_addr;
    assign wreg  = waddr[8:0];
    assign raddr = item.reg_addr & READ_MASK;

    always_comb
    begin
        reload1_next = reload1_reg;
        reload2_next = reload2_reg;
        control_next = control_reg;
        ctl_write    = 1'b0;
        clear_all    = 1'b0;
        if (fire && item.func == FUNC_WRITE)
        begin
            case (wreg)
                REG_RELOAD1: reload1_next = item.wdata;
                REG_RELOAD2: reload2_next = item.wdata;
                REG_CONTROL:
                begin
                    if (item.wdata[7])
                    begin
                        clear_all = 1'b1;
                    end
                    else
                    begin
                        ctl_write    = 1'b1;
                        control_next = item.wdata;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cmd1.tick  = fire && item.func == FUNC_TICK1;
        cmd1.start = ctl_write && item.wdata[0];
        cmd1.stop  = ctl_write && !item.wdata[0];
        cmd2.tick  = fire && item.func == FUNC_TICK2;
        cmd2.start = ctl_write && item.wdata[1];
        cmd2.stop  = ctl_write && !item.wdata[1];
    end

    fmtp_timer u_timer1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd1),
        .reload (reload1_reg),
        .mask   (control_next[6]),
        .opl3   (opl3_mode),
        .ovf    (ovf1)
    );

    fmtp_timer u_timer2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd2),
        .reload (reload2_reg),
        .mask   (control_next[5]),
        .opl3   (opl3_mode),
        .ovf    (ovf2)
    );

    always_comb
    begin
        flags_next = flags_reg;
        if (clear_all)
        begin
            flags_next = 2'b00;
        end
        else
        begin
            if (cmd1.stop)
                flags_next[0] = 1'b0;
            if (ovf1)
                flags_next[0] = 1'b1;
            if (cmd2.stop)
                flags_next[1] = 1'b0;
            if (ovf2)
                flags_next[1] = 1'b1;
        end
    end

    always_comb
    begin
        result.rdata    = NO_ANSWER;
        result.answered = 1'b0;
        case (item.func)
            FUNC_STATUS:
            begin
                result.rdata    = {|flags_reg, flags_reg[0], flags_reg[1], 5'b00000};
                result.answered = 1'b1;
            end
            FUNC_READ:
            begin
                case (raddr)
                    READ_RELOAD1:
                    begin
                        result.rdata    = reload1_reg;
                        result.answered = 1'b1;
                    end
                    READ_RELOAD2:
                    begin
                        result.rdata    = reload2_reg;
                        result.answered = 1'b1;
                    end
                    READ_CONTROL:
                    begin
                        result.rdata    = control_reg;
                        result.answered = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            control_reg <= '0;
            reload1_reg <= '0;
            reload2_reg <= '0;
        end
        else
        begin
            flags_reg   <= flags_next;
            control_reg <= control_next;
            reload1_reg <= reload1_next;
            reload2_reg <= reload2_next;
        end
    end

endmodule

// File: rtl/fm_sound_timer_pair.sv
// Throughput: one word per cycle while result words are taken (rsp.ready);
// a word goes through the input register, one pass through the
// decode and timer update logic, and the result register.
// Reset: rst_n clears both timers, flags, control and reload bytes, and
// sets opl3 mode, clears native mode.
module fm_sound_timer_pair
    import fmtp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    fmtp_in_if.sink    req,
    fmtp_out_if.source rsp,
    input  logic   cfg_we,
    input  logic   cfg_index,
    input  logic   cfg_wdata
);

    logic      native_reg;
    logic      opl3_reg;
    logic      s1_valid_reg;
    in_word_t  s1_item_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t result;
    logic      out_adv;
    logic      fire;

    assign out_adv   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && out_adv;
    assign req.ready = !s1_valid_reg || out_adv;

    assign rsp.valid    = out_valid_reg;
    assign rsp.rdata    = out_word_reg.rdata;
    assign rsp.answered = out_word_reg.answered;

    fmtp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .high_map  (native_reg),
        .opl3_mode (opl3_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            native_reg <= 1'b0;
            opl3_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_MAP:  native_reg <= cfg_wdata;
                CFG_OPL3_MODE: opl3_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg.func     <= req.func;
            s1_item_reg.reg_addr <= req.reg_addr;
            s1_item_reg.wdata    <= req.wdata;
        end
        if (fire)
            out_word_reg <= result;
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb
    import fmtp_pkg::*;
();

    localparam int CTRL_START1 = 0;
    localparam int CTRL_START2 = 1;
    localparam int CTRL_MASK2  = 5;
    localparam int CTRL_MASK1  = 6;
    localparam int CTRL_CLEAR  = 7;

    localparam int STAT_T2  = 5;
    localparam int STAT_T1  = 6;
    localparam int STAT_ANY = 7;

    localparam bit [3:0] NATIVE_SEQ = 4'b0110;
    localparam bit [3:0] OPL3_SEQ   = 4'b0101;
    localparam int       PHASE_WORDS = 350;
    localparam int       LONG_HOLD   = 80;

    class timer_scoreboard;
        bit          native;
        bit          opl3;
        logic [1:0]  flags;
        logic [7:0]  control;
        logic [7:0]  reload [2];
        logic [7:0]  count [2];
        bit          run [2];
        out_word_t   pending_answers [$];
        int unsigned errors;

        function new();
            native  = 1'b0;
            opl3    = 1'b1;
            flags   = '0;
            control = '0;
            errors  = 0;
            for (int t = 0; t < 2; t++)
            begin
                reload[t] = '0;
                count[t]  = '0;
                run[t]    = 1'b0;
            end
        endfunction

        function void count_up(int t);
            count[t] = count[t] + 8'd1;
            if (count[t] == 8'd0)
            begin
                if (!control[(t == 0) ? CTRL_MASK1 : CTRL_MASK2])
                    flags[t] = 1'b1;
                count[t] = reload[t];
            end
        endfunction

        function void set_run(int t, bit on);
            if (on)
            begin
                run[t]   = 1'b1;
                count[t] = reload[t];
                if (opl3)
                    count_up(t);
            end
            else
            begin
                run[t]   = 1'b0;
                flags[t] = 1'b0;
            end
        endfunction

        function out_word_t answer_for(in_word_t w);
            out_word_t   r;
            logic [10:0] a;
            r.rdata    = NO_ANSWER;
            r.answered = 1'b0;
            case (w.func)
                FUNC_TICK1:
                    if (run[0])
                        count_up(0);
                FUNC_TICK2:
                    if (run[1])
                        count_up(1);
                FUNC_WRITE:
                begin
                    a = native ? w.reg_addr - NATIVE_BASE : w.reg_addr;
                    case (a[8:0])
                        REG_RELOAD1: reload[0] = w.wdata;
                        REG_RELOAD2: reload[1] = w.wdata;
                        REG_CONTROL:
                        begin
                            if (w.wdata[CTRL_CLEAR])
                                flags = '0;
                            else
                            begin
                                control = w.wdata;
                                set_run(0, w.wdata[CTRL_START1]);
                                set_run(1, w.wdata[CTRL_START2]);
                            end
                        end
                        default: ;
                    endcase
                end
                FUNC_STATUS:
                begin
                    r.rdata           = 8'h00;
                    r.rdata[STAT_T1]  = flags[0];
                    r.rdata[STAT_T2]  = flags[1];
                    r.rdata[STAT_ANY] = |flags;
                    r.answered        = 1'b1;
                end
                FUNC_READ:
                begin
                    r.answered = 1'b1;
                    case (w.reg_addr & READ_MASK)
                        READ_RELOAD1: r.rdata = reload[0];
                        READ_RELOAD2: r.rdata = reload[1];
                        READ_CONTROL: r.rdata = control;
                        default:      r.answered = 1'b0;
                    endcase
                end
                default: ;
            endcase
            return r;
        endfunction

        function void note_word(in_word_t w);
            pending_answers.push_back(answer_for(w));
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (pending_answers.size() == 0)
            begin
                $error("unexpected word: rdata %02h answered %0b", got.rdata, got.answered);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.rdata !== want.rdata)
            begin
                $error("rdata: expected %02h, actual %02h", want.rdata, got.rdata);
                errors++;
            end
            if (got.answered !== want.answered)
            begin
                $error("answered: expected %0b, actual %0b", want.answered, got.answered);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_wdata;

    fmtp_in_if  req_if ();
    fmtp_out_if rsp_if ();

    timer_scoreboard sb = new();
    int unsigned     words_sent;
    int unsigned     words_taken;

    fm_sound_timer_pair i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic in_word_t mk_word(logic [2:0] f, logic [10:0] a, logic [7:0] d);
        in_word_t w;
        w.func     = f;
        w.reg_addr = a;
        w.wdata    = d;
        return w;
    endfunction

    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        w.reg_addr = 11'($urandom);
        w.wdata    = 8'($urandom);
        if (pick < 22)
            w.func = FUNC_TICK1;
        else if (pick < 44)
            w.func = FUNC_TICK2;
        else if (pick < 72)
        begin
            w.func = FUNC_WRITE;
            if ($urandom_range(0, 9) < 8)
                w.reg_addr = {2'($urandom_range(0, 3)), 9'($urandom_range(2, 4))};
            if (w.reg_addr[8:0] == REG_CONTROL)
                w.wdata[CTRL_CLEAR] = ($urandom_range(0, 4) == 0);
            else if ($urandom_range(0, 1) == 1)
                w.wdata = 8'($urandom_range(8'hf8, 8'hff));
        end
        else if (pick < 80)
            w.func = FUNC_STATUS;
        else if (pick < 95)
        begin
            w.func = FUNC_READ;
            if ($urandom_range(0, 9) < 7)
                w.reg_addr = {1'b1, 1'($urandom), 9'($urandom_range(2, 4))};
        end
        else
            w.func = 3'($urandom_range(FUNC_READ + 1, 3'h7));
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        int unsigned gap;
        gap = ((words_sent / 64) % 3 != 0) ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.func     <= w.func;
        req_if.reg_addr <= w.reg_addr;
        req_if.wdata    <= w.wdata;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_modes(bit native, bit opl3);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HIGH_MAP;
        cfg_wdata <= native;
        @(posedge clk);
        sb.native = native;
        cfg_index <= CFG_OPL3_MODE;
        cfg_wdata <= opl3;
        @(posedge clk);
        sb.opl3 = opl3;
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        send_word(mk_word(FUNC_STATUS, 11'h000, 8'h00));
        send_word(mk_word(FUNC_READ,   READ_RELOAD1, 8'h00));
        send_word(mk_word(FUNC_TICK1,  11'h000, 8'h00));
        send_word(mk_word(FUNC_WRITE,  11'h002, 8'hfe));
        send_word(mk_word(FUNC_WRITE,  11'h403, 8'hff));
        send_word(mk_word(FUNC_READ,   READ_RELOAD2, 8'h00));
        send_word(mk_word(FUNC_READ,   11'h602, 8'h00));
        send_word(mk_word(FUNC_READ,   11'h405, 8'hff));
        send_word(mk_word(FUNC_WRITE,  11'h004, 8'h03));
        send_word(mk_word(FUNC_STATUS, 11'h7ff, 8'hff));
        send_word(mk_word(FUNC_TICK1,  11'h7ff, 8'hff));
        send_word(mk_word(FUNC_STATUS, 11'h000, 8'h00));
        send_word(mk_word(FUNC_READ,   READ_CONTROL, 8'h00));
        send_word(mk_word(FUNC_WRITE,  11'h204, 8'h80));
        send_word(mk_word(FUNC_STATUS, 11'h000, 8'h00));
        send_word(mk_word(FUNC_WRITE,  11'h004, 8'h43));
        send_word(mk_word(FUNC_TICK1,  11'h000, 8'h00));
        send_word(mk_word(FUNC_STATUS, 11'h000, 8'h00));
        send_word(mk_word(FUNC_WRITE,  11'h004, 8'h41));
        send_word(mk_word(FUNC_TICK2,  11'h000, 8'h00));
        send_word(mk_word(FUNC_STATUS, 11'h000, 8'h00));
        send_word(mk_word(FUNC_WRITE,  11'h7ff, 8'hff));
        send_word(mk_word(FUNC_READ + 3'd1, 11'h7ff, 8'hff));
        send_word(mk_word(FUNC_READ + 3'd2, 11'h000, 8'h00));
        send_word(mk_word(FUNC_READ + 3'd3, 11'h404, 8'h55));
        send_word(mk_word(FUNC_WRITE,  11'h004, 8'h00));
        send_word(mk_word(FUNC_READ,   11'h000, 8'h00));
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_HIGH_MAP;
        cfg_wdata       = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FUNC_TICK1;
        req_if.reg_addr = '0;
        req_if.wdata    = '0;
        words_sent      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int p = 0; p < 4; p++)
        begin
            set_modes(NATIVE_SEQ[p], OPL3_SEQ[p]);
            if (p == 0)
                run_directed();
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (p == 2 && i == PHASE_WORDS / 2)
                    drain();
                send_word(random_word());
            end
            drain();
        end
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned pause;
        rsp_if.ready = 1'b0;
        words_taken  = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pause = ((words_taken / 48) % 3 != 1) ? $urandom_range(0, 3) : 0;
            if (words_taken == 500)
                pause = LONG_HOLD;
            if (pause > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid && rsp_if.ready));
            sb.check_word(out_word_t'({rsp_if.rdata, rsp_if.answered}));
            words_taken++;
        end
    end

endmodule
